### rtl/tagstr_pkg.sv
// Shared types and constants for the in-band tag block stripper.
`timescale 1ns / 1ps

package tagstr_pkg;

  localparam int unsigned HDR_LEN = 6;

  localparam logic [7:0] AT_CHAR    = 8'h40;
  localparam logic [7:0] QUOTE_CHAR = 8'h22;
  localparam logic [7:0] CLOSE_CHAR = 8'h5D;

  localparam logic [2:0] PROG_IN_BLOCK = 3'(HDR_LEN);

  // One burst of results caused by one input byte:
  // the first held_cnt header bytes, then optionally one extra byte.
  // A burst with no bytes at all is a bare end marker.
  typedef struct packed {
    logic [2:0] held_cnt;
    logic       has_extra;
    logic [7:0] extra;
    logic       last;
    logic       unterm;
  } burst_t;

  // Header text "@+VFX["
  function automatic logic [7:0] hdr_char(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = 8'h40;
      3'd1:    c = 8'h2B;
      3'd2:    c = 8'h56;
      3'd3:    c = 8'h46;
      3'd4:    c = 8'h58;
      3'd5:    c = 8'h5B;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

### rtl/tagstr_parse.sv
// Header matcher and block tracker: turns each input byte into at most one result burst.
`timescale 1ns / 1ps

module tagstr_parse (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          in_data_byte,
  input  logic                in_stream_end,
  output logic                burst_valid,
  input  logic                burst_ready,
  output tagstr_pkg::burst_t  burst
);
  import tagstr_pkg::*;

  logic [2:0] prog_r, prog_nxt;
  logic       quote_r, quote_nxt;
  burst_t     burst_r, burst_nxt;
  logic       burst_vld_r;
  logic       produce;
  logic       in_block;
  logic       accept;

  assign in_block = (prog_r >= PROG_IN_BLOCK);

  always_comb begin
    prog_nxt  = prog_r;
    quote_nxt = quote_r;
    burst_nxt = '0;
    burst_nxt.extra = in_data_byte;
    burst_nxt.last  = in_stream_end;
    if (in_block) begin
      if (in_data_byte == QUOTE_CHAR) begin
        quote_nxt = ~quote_r;
      end else if (in_data_byte == CLOSE_CHAR && !quote_r) begin
        prog_nxt  = '0;
        quote_nxt = 1'b0;
      end
    end else if (in_data_byte == hdr_char(prog_r)) begin
      prog_nxt = prog_r + 3'd1;
      if (prog_nxt == PROG_IN_BLOCK) begin
        quote_nxt = 1'b0;
      end
      // partial header at end of stream is plain data
      if (in_stream_end && prog_nxt < PROG_IN_BLOCK) begin
        burst_nxt.held_cnt = prog_nxt;
      end
    end else begin
      // mismatch: release held bytes; a stray '@' starts a new match
      burst_nxt.held_cnt  = prog_r;
      burst_nxt.has_extra = (in_data_byte != AT_CHAR) || in_stream_end;
      prog_nxt = (in_data_byte == AT_CHAR) ? 3'd1 : 3'd0;
    end
    if (in_stream_end) begin
      burst_nxt.unterm = (prog_nxt >= PROG_IN_BLOCK);
      prog_nxt  = '0;
      quote_nxt = 1'b0;
    end
  end

  assign produce  = in_stream_end || burst_nxt.has_extra || (burst_nxt.held_cnt != 3'd0);
  assign in_ready = !burst_vld_r || burst_ready;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prog_r      <= '0;
      quote_r     <= 1'b0;
      burst_vld_r <= 1'b0;
    end else begin
      if (burst_vld_r && burst_ready) begin
        burst_vld_r <= 1'b0;
      end
      if (accept) begin
        prog_r  <= prog_nxt;
        quote_r <= quote_nxt;
        if (produce) begin
          burst_vld_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && produce) begin
      burst_r <= burst_nxt;
    end
  end

  assign burst_valid = burst_vld_r;
  assign burst       = burst_r;

endmodule

### rtl/tagstr_emit.sv
// Result sequencer: plays out one burst as a series of result requests.
`timescale 1ns / 1ps

module tagstr_emit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                burst_valid,
  output logic                burst_ready,
  input  tagstr_pkg::burst_t  burst,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [7:0]          out_byte,
  output logic                out_has_byte,
  output logic                out_stream_done,
  output logic                out_unterminated
);
  import tagstr_pkg::*;

  burst_t     cur_r;
  logic       busy_r;
  logic [2:0] idx_r;
  logic [2:0] total;
  logic       marker;
  logic       is_last;

  assign total   = cur_r.held_cnt + {2'b00, cur_r.has_extra};
  assign marker  = (total == 3'd0);
  assign is_last = marker || ((idx_r + 3'd1) == total);

  assign burst_ready = !busy_r || (out_ready && is_last);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= '0;
    end else if (burst_valid && burst_ready) begin
      busy_r <= 1'b1;
      idx_r  <= '0;
    end else if (busy_r && out_ready) begin
      if (is_last) begin
        busy_r <= 1'b0;
      end else begin
        idx_r <= idx_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (burst_valid && burst_ready) begin
      cur_r <= burst;
    end
  end

  always_comb begin
    if (idx_r < cur_r.held_cnt) begin
      out_byte = hdr_char(idx_r);
    end else if (cur_r.has_extra) begin
      out_byte = cur_r.extra;
    end else begin
      out_byte = 8'h00;
    end
  end

  assign out_valid        = busy_r;
  assign out_has_byte     = !marker;
  assign out_stream_done  = cur_r.last && is_last;
  assign out_unterminated = cur_r.last && cur_r.unterm && is_last;

endmodule

### rtl/inband_tag_block_stripper.sv
// Top level of the in-band tag block stripper: removes "@+VFX[ ... ]" blocks from a byte stream.
// Takes one byte per cycle while each byte yields at most one result and out_ready is high; a byte
// that releases held header bytes produces up to 6 results, one per cycle while out_ready is high,
// so input pauses while the result sequencer plays out such a burst. A one-entry burst register sits
// between the matcher and the sequencer, so a new byte is taken while the current result waits on
// out_ready. Bytes of a partially matched header are held until the match completes or fails. At
// stream end the last result carries stream_done, plus unterminated if a block was still open; with
// nothing to emit a bare end marker (has_byte low) is returned.
`timescale 1ns / 1ps

module inband_tag_block_stripper (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_data_byte,
  input  logic       in_stream_end,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_has_byte,
  output logic       out_stream_done,
  output logic       out_unterminated
);
  import tagstr_pkg::*;

  burst_t burst;
  logic   burst_valid;
  logic   burst_ready;

  tagstr_parse u_parse (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data_byte  (in_data_byte),
    .in_stream_end (in_stream_end),
    .burst_valid   (burst_valid),
    .burst_ready   (burst_ready),
    .burst         (burst)
  );

  tagstr_emit u_emit (
    .clk              (clk),
    .rst_n            (rst_n),
    .burst_valid      (burst_valid),
    .burst_ready      (burst_ready),
    .burst            (burst),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_byte         (out_byte),
    .out_has_byte     (out_has_byte),
    .out_stream_done  (out_stream_done),
    .out_unterminated (out_unterminated)
  );

endmodule

### tb/sv/tb_top.sv
// Self-checking testbench for the in-band tag block stripper.
`timescale 1ns / 1ps

module tb_top;
  import tagstr_pkg::*;

  typedef struct packed {
    logic [7:0] ob;
    logic       has;
    logic       done;
    logic       unterm;
  } out_rec_t;

  typedef struct packed {
    logic [7:0] b;
    logic       fin;
    logic       typed;
    out_rec_t   want;
  } dir_row_t;

  localparam logic [7:0] TAG_HDR [HDR_LEN] = '{8'h40, 8'h2B, 8'h56, 8'h46, 8'h58, 8'h5B};
  localparam int DIR_N = 25;
  localparam int RAND_N = 235;

  // typed rows carry their result; the rest go through the predictor
  localparam dir_row_t DIR_ROWS [DIR_N] = '{
    '{8'h00,       1'b0, 1'b1, '{8'h00, 1'b1, 1'b0, 1'b0}},
    '{TAG_HDR[0],  1'b0, 1'b0, '0},
    '{TAG_HDR[1],  1'b0, 1'b0, '0},
    '{TAG_HDR[2],  1'b0, 1'b0, '0},
    '{TAG_HDR[3],  1'b0, 1'b0, '0},
    '{TAG_HDR[4],  1'b0, 1'b0, '0},
    '{TAG_HDR[5],  1'b0, 1'b0, '0},
    '{QUOTE_CHAR,  1'b0, 1'b0, '0},
    '{CLOSE_CHAR,  1'b0, 1'b0, '0},
    '{QUOTE_CHAR,  1'b0, 1'b0, '0},
    '{CLOSE_CHAR,  1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b0}},
    '{AT_CHAR,     1'b0, 1'b0, '0},
    '{AT_CHAR,     1'b0, 1'b0, '0},
    '{TAG_HDR[1],  1'b0, 1'b0, '0},
    '{TAG_HDR[2],  1'b0, 1'b0, '0},
    '{TAG_HDR[3],  1'b0, 1'b0, '0},
    '{TAG_HDR[4],  1'b0, 1'b0, '0},
    '{8'hFF,       1'b0, 1'b0, '0},
    '{AT_CHAR,     1'b1, 1'b1, '{AT_CHAR, 1'b1, 1'b1, 1'b0}},
    '{TAG_HDR[0],  1'b0, 1'b0, '0},
    '{TAG_HDR[1],  1'b0, 1'b0, '0},
    '{TAG_HDR[2],  1'b0, 1'b0, '0},
    '{TAG_HDR[3],  1'b0, 1'b0, '0},
    '{TAG_HDR[4],  1'b0, 1'b0, '0},
    '{TAG_HDR[5],  1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b1}}
  };

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_data_byte = 8'h00;
  logic       in_stream_end = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_byte;
  logic       out_has_byte;
  logic       out_stream_done;
  logic       out_unterminated;

  inband_tag_block_stripper dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data_byte     (in_data_byte),
    .in_stream_end    (in_stream_end),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_byte         (out_byte),
    .out_has_byte     (out_has_byte),
    .out_stream_done  (out_stream_done),
    .out_unterminated (out_unterminated)
  );

  always #5 clk = ~clk;

  // predictor state
  logic [2:0] hdr_seen = 3'd0;
  logic       in_quotes = 1'b0;
  out_rec_t   step_out [$];
  out_rec_t   pending_out [$];

  int err_cnt = 0;
  int req_cnt = 0;
  bit in_calm = 1'b0;
  bit out_calm = 1'b0;
  int stall_left = 0;
  int phase_left = 0;

  function automatic void put_out(input logic [7:0] b);
    step_out.push_back('{b, 1'b1, 1'b0, 1'b0});
  endfunction

  function automatic void put_held(input int n);
    for (int i = 0; i < n; i++) put_out(TAG_HDR[i]);
  endfunction

  // results caused by one byte; leaves them in step_out
  function automatic void strip_byte(input logic [7:0] b, input logic fin);
    logic [2:0] p;
    out_rec_t   r;
    p = hdr_seen;
    step_out.delete();
    if (p >= HDR_LEN) begin
      if (b == QUOTE_CHAR) begin
        in_quotes = ~in_quotes;
      end else if (b == CLOSE_CHAR && !in_quotes) begin
        p = 3'd0;
        in_quotes = 1'b0;
      end
    end else if (b == TAG_HDR[p]) begin
      p = p + 3'd1;
      if (p == HDR_LEN) in_quotes = 1'b0;
    end else begin
      put_held(int'(p));
      if (b == AT_CHAR) begin
        p = 3'd1;
      end else begin
        put_out(b);
        p = 3'd0;
      end
    end
    hdr_seen = p;
    if (fin) begin
      if (p < HDR_LEN) put_held(int'(p));
      if (step_out.size() == 0) step_out.push_back('0);
      r = step_out.pop_back();
      r.done = 1'b1;
      r.unterm = (p >= HDR_LEN);
      step_out.push_back(r);
      hdr_seen = 3'd0;
      in_quotes = 1'b0;
    end
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (in_calm || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 25);
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic fin, input logic typed,
                           input out_rec_t want);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_data_byte  <= b;
    in_stream_end <= fin;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    strip_byte(b, fin);
    if (typed) begin
      pending_out.push_back(want);
    end else begin
      foreach (step_out[i]) pending_out.push_back(step_out[i]);
    end
    req_cnt++;
  endtask

  // random byte; now and then it ends the stream wherever it falls
  task automatic send_rand(input logic [7:0] b);
    send_byte(b, ($urandom_range(0, 29) == 0), 1'b0, '0);
  endtask

  task automatic drain_output();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_out.size() != 0);
  endtask

  initial begin
    int  kind;
    int  n;
    int  next_drain;
    bit  q;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < DIR_N; i++)
      send_byte(DIR_ROWS[i].b, DIR_ROWS[i].fin, DIR_ROWS[i].typed, DIR_ROWS[i].want);
    drain_output();

    next_drain = req_cnt + 90;
    while (req_cnt < DIR_N + RAND_N) begin
      if ($urandom_range(0, 7) == 0) in_calm = !in_calm;
      kind = $urandom_range(0, 9);
      if (kind < 5) begin
        // well-formed block, quoted brackets inside
        n = $urandom_range(0, 3);
        for (int i = 0; i < n; i++) send_rand(8'($urandom_range(0, 255)));
        for (int i = 0; i < HDR_LEN; i++) send_rand(TAG_HDR[i]);
        q = 1'b0;
        n = $urandom_range(0, 8);
        for (int i = 0; i < n; i++) begin
          case ($urandom_range(0, 5))
            0, 1: begin
              send_rand(QUOTE_CHAR);
              q = !q;
            end
            2: send_rand(q ? CLOSE_CHAR : 8'($urandom_range(0, 255)));
            default: send_rand(8'($urandom_range(0, 255)));
          endcase
        end
        if (q) send_rand(QUOTE_CHAR);
        send_rand(CLOSE_CHAR);
      end else if (kind < 7) begin
        // header broken off after a few bytes
        n = $urandom_range(1, 5);
        for (int i = 0; i < n; i++) send_rand(TAG_HDR[i]);
        send_rand(($urandom_range(0, 2) == 0) ? AT_CHAR : 8'($urandom_range(0, 255)));
      end else if (kind < 9) begin
        n = $urandom_range(1, 4);
        for (int i = 0; i < n; i++) send_rand(8'($urandom_range(0, 255)));
      end else begin
        send_byte(8'($urandom_range(0, 255)), 1'b1, 1'b0, '0);
      end
      if (req_cnt >= next_drain) begin
        drain_output();
        next_drain = req_cnt + 90;
      end
    end

    in_valid <= 1'b0;
    while (pending_out.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (err_cnt == 0) begin
      $display("** inband_tag_block_stripper: PASSED **");
    end else begin
      $display("** inband_tag_block_stripper: FAILED **");
    end
    $finish;
  end

  // result checker and receiver back-pressure
  always @(posedge clk) begin
    out_rec_t want;
    int       r;
    if (rst_n && out_valid && out_ready) begin
      if (pending_out.size() == 0) begin
        $display("%0t: unexpected result byte %02h has %0b done %0b unterm %0b", $time,
                 out_byte, out_has_byte, out_stream_done, out_unterminated);
        err_cnt++;
      end else begin
        want = pending_out.pop_front();
        if (out_byte !== want.ob) begin
          $display("%0t: out_byte exp %02h got %02h", $time, want.ob, out_byte);
          err_cnt++;
        end
        if (out_has_byte !== want.has) begin
          $display("%0t: out_has_byte exp %0b got %0b", $time, want.has, out_has_byte);
          err_cnt++;
        end
        if (out_stream_done !== want.done) begin
          $display("%0t: out_stream_done exp %0b got %0b", $time, want.done, out_stream_done);
          err_cnt++;
        end
        if (out_unterminated !== want.unterm) begin
          $display("%0t: out_unterminated exp %0b got %0b", $time, want.unterm,
                   out_unterminated);
          err_cnt++;
        end
      end
    end
    if (phase_left == 0) begin
      out_calm = ($urandom_range(0, 3) == 0);
      phase_left = $urandom_range(40, 300);
    end else begin
      phase_left--;
    end
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      if (!out_calm) begin
        r = $urandom_range(0, 99);
        if (r < 25) stall_left = $urandom_range(1, 3);
        else if (r < 29) stall_left = $urandom_range(10, 30);
      end
    end
  end

  initial begin
    #5_000_000;
    $display("** inband_tag_block_stripper: FAILED **");
    $finish;
  end

endmodule

### inband_tag_block_stripper.f
rtl/tagstr_pkg.sv
rtl/tagstr_parse.sv
rtl/tagstr_emit.sv
rtl/inband_tag_block_stripper.sv
tb/sv/tb_top.sv
